// ----- hdl/mcma_pkg.sv -----
// Package for the multiplexed control moving-average unit.
// Holds sample widths, window sizes, frame phases and derived widths.
// No dependencies.
package mcma_pkg;

  localparam int unsigned SAMPLE_BITS = 12;
  // Both windows are powers of two, so an average is a plain shift of its sum.
  localparam int unsigned KNOB_WINDOW = 32;
  localparam int unsigned CV_WINDOW   = 4;
  localparam int unsigned FRAME_TICKS = 32;

  localparam int unsigned PAIR_PHASE   = 1;
  localparam int unsigned SECOND_PHASE = 16;

  localparam int unsigned KNOB_SHIFT = $clog2(KNOB_WINDOW);
  localparam int unsigned CV_SHIFT   = $clog2(CV_WINDOW);
  localparam int unsigned KIDX_W     = KNOB_SHIFT;
  localparam int unsigned CIDX_W     = CV_SHIFT;
  localparam int unsigned KSUM_W     = SAMPLE_BITS + KNOB_SHIFT;
  localparam int unsigned CSUM_W     = SAMPLE_BITS + CV_SHIFT;
  localparam int unsigned PHASE_W    = $clog2(FRAME_TICKS + 1);

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [KSUM_W-1:0]      ksum_t;
  typedef logic [CSUM_W-1:0]      csum_t;
  typedef logic [KIDX_W-1:0]      kidx_t;
  typedef logic [CIDX_W-1:0]      cidx_t;
  typedef logic [PHASE_W-1:0]     phase_t;

endpackage

// ----- hdl/mcma_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Used for the knob sample rings. No dependencies.
module mcma_ram #(
  parameter int unsigned WIDTH = 12,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/multiplexed_control_moving_average_unit.sv -----
// A taken transaction is registered in the ring stage, then in the output register.
// Throughput: one transaction per cycle unless the output stalls. In each knob RAM,
// one read port serves the ring read at acceptance, one write port the write-back.
// Reset clears the phase counter, running sums, ring fill flags, the CV ring and the
// held averages. Knob RAM contents are not cleared: a fill flag per ring makes slots
// not yet written read as zero, so no clearing pass is needed.
module multiplexed_control_moving_average_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [mcma_pkg::SAMPLE_BITS-1:0]     knob1_raw_i,
  input  logic [mcma_pkg::SAMPLE_BITS-1:0]     knob2_raw_i,
  input  logic [mcma_pkg::SAMPLE_BITS-1:0]     knob3_raw_i,
  input  logic [mcma_pkg::SAMPLE_BITS-1:0]     cv_raw_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [mcma_pkg::SAMPLE_BITS-1:0]     knob1_avg_o,
  output logic [mcma_pkg::SAMPLE_BITS-1:0]     knob2_avg_o,
  output logic [mcma_pkg::SAMPLE_BITS-1:0]     knob3_avg_o,
  output logic [mcma_pkg::SAMPLE_BITS-1:0]     cv_avg_o
);

  localparam int unsigned SB = mcma_pkg::SAMPLE_BITS;

  // Accept stage and phase counter.
  logic              accept;
  logic              adv1;
  mcma_pkg::phase_t  phase_q, phase_d;
  logic              pair_hit, second_hit;

  // Ring stage.
  logic              s1_valid_q;
  logic              s1_pair_q, s1_second_q;
  mcma_pkg::sample_t s1_k1_q, s1_k2_q, s1_k3_q, s1_cv_q;

  // Ring state.
  mcma_pkg::kidx_t   pair_idx_q, sec_idx_q;
  logic              pair_full_q, sec_full_q;
  mcma_pkg::cidx_t   cv_idx_q;
  mcma_pkg::sample_t cv_ring_q [mcma_pkg::CV_WINDOW];
  mcma_pkg::ksum_t   k1_sum_q, k2_sum_q, k3_sum_q;
  mcma_pkg::csum_t   cv_sum_q;
  mcma_pkg::ksum_t   k1_sum_d, k2_sum_d, k3_sum_d;
  mcma_pkg::csum_t   cv_sum_d;
  mcma_pkg::sample_t held1_q, held2_q, held3_q, held4_q;
  mcma_pkg::sample_t held1_d, held2_d, held3_d, held4_d;

  logic [2*SB-1:0]   pair_rdata;
  mcma_pkg::sample_t k3_rdata;
  mcma_pkg::sample_t old_k1, old_k2, old_k3, old_cv;

  // Output register.
  logic              out_valid_q;
  mcma_pkg::sample_t out1_q, out2_q, out3_q, out4_q;

  assign adv1       = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || adv1;
  assign accept     = in_valid_i && in_ready_o;

  assign pair_hit   = (phase_q == mcma_pkg::PHASE_W'(mcma_pkg::PAIR_PHASE));
  assign second_hit = (phase_q == mcma_pkg::PHASE_W'(mcma_pkg::SECOND_PHASE));
  assign phase_d    = (phase_q >= mcma_pkg::PHASE_W'(mcma_pkg::FRAME_TICKS)) ?
                      mcma_pkg::PHASE_W'(1) : phase_q + mcma_pkg::PHASE_W'(1);

  // Knob 1 and knob 2 share a write index, so they share one RAM word.
  mcma_ram #(
    .WIDTH (2 * SB),
    .DEPTH (mcma_pkg::KNOB_WINDOW)
  ) u_pair_ram (
    .clk_i   (clk_i),
    .we_i    (adv1 && s1_pair_q),
    .waddr_i (pair_idx_q),
    .wdata_i ({s1_k2_q, s1_k1_q}),
    .re_i    (accept && pair_hit),
    .raddr_i (pair_idx_q),
    .rdata_o (pair_rdata)
  );

  mcma_ram #(
    .WIDTH (SB),
    .DEPTH (mcma_pkg::KNOB_WINDOW)
  ) u_knob3_ram (
    .clk_i   (clk_i),
    .we_i    (adv1 && s1_second_q),
    .waddr_i (sec_idx_q),
    .wdata_i (s1_k3_q),
    .re_i    (accept && second_hit),
    .raddr_i (sec_idx_q),
    .rdata_o (k3_rdata)
  );

  // A knob slot that the write index has not yet passed reads as zero by its fill flag.
  // The frame is longer than one tick, so a ring is never touched by two
  // transactions in flight at once and the read needs no forwarding.
  assign old_k1 = pair_full_q ? pair_rdata[SB-1:0]    : '0;
  assign old_k2 = pair_full_q ? pair_rdata[2*SB-1:SB] : '0;
  assign old_k3 = sec_full_q  ? k3_rdata              : '0;
  assign old_cv = cv_ring_q[cv_idx_q];

  always_comb begin
    k1_sum_d = k1_sum_q;
    k2_sum_d = k2_sum_q;
    k3_sum_d = k3_sum_q;
    cv_sum_d = cv_sum_q;
    held1_d  = held1_q;
    held2_d  = held2_q;
    held3_d  = held3_q;
    held4_d  = held4_q;
    if (s1_pair_q) begin
      k1_sum_d = k1_sum_q + mcma_pkg::KSUM_W'(s1_k1_q) - mcma_pkg::KSUM_W'(old_k1);
      k2_sum_d = k2_sum_q + mcma_pkg::KSUM_W'(s1_k2_q) - mcma_pkg::KSUM_W'(old_k2);
      held1_d  = k1_sum_d[mcma_pkg::KNOB_SHIFT +: SB];
      held2_d  = k2_sum_d[mcma_pkg::KNOB_SHIFT +: SB];
    end
    if (s1_second_q) begin
      k3_sum_d = k3_sum_q + mcma_pkg::KSUM_W'(s1_k3_q) - mcma_pkg::KSUM_W'(old_k3);
      cv_sum_d = cv_sum_q + mcma_pkg::CSUM_W'(s1_cv_q) - mcma_pkg::CSUM_W'(old_cv);
      held3_d  = k3_sum_d[mcma_pkg::KNOB_SHIFT +: SB];
      held4_d  = cv_sum_d[mcma_pkg::CV_SHIFT +: SB];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= '0;
      s1_valid_q  <= 1'b0;
      s1_pair_q   <= 1'b0;
      s1_second_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        phase_q     <= phase_d;
        s1_pair_q   <= pair_hit;
        s1_second_q <= second_hit;
      end
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (adv1) begin
        s1_valid_q <= 1'b0;
      end
      if (adv1) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_k1_q <= knob1_raw_i;
      s1_k2_q <= knob2_raw_i;
      s1_k3_q <= knob3_raw_i;
      s1_cv_q <= cv_raw_i;
    end
    if (adv1) begin
      out1_q <= held1_d;
      out2_q <= held2_d;
      out3_q <= held3_d;
      out4_q <= held4_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_idx_q  <= '0;
      sec_idx_q   <= '0;
      cv_idx_q    <= '0;
      pair_full_q <= 1'b0;
      sec_full_q  <= 1'b0;
      k1_sum_q    <= '0;
      k2_sum_q    <= '0;
      k3_sum_q    <= '0;
      cv_sum_q    <= '0;
      held1_q     <= '0;
      held2_q     <= '0;
      held3_q     <= '0;
      held4_q     <= '0;
      for (int i = 0; i < mcma_pkg::CV_WINDOW; i++) begin
        cv_ring_q[i] <= '0;
      end
    end else if (adv1) begin
      k1_sum_q <= k1_sum_d;
      k2_sum_q <= k2_sum_d;
      k3_sum_q <= k3_sum_d;
      cv_sum_q <= cv_sum_d;
      held1_q  <= held1_d;
      held2_q  <= held2_d;
      held3_q  <= held3_d;
      held4_q  <= held4_d;
      if (s1_pair_q) begin
        if (pair_idx_q == mcma_pkg::KIDX_W'(mcma_pkg::KNOB_WINDOW - 1)) begin
          pair_idx_q  <= '0;
          pair_full_q <= 1'b1;
        end else begin
          pair_idx_q <= pair_idx_q + mcma_pkg::KIDX_W'(1);
        end
      end
      if (s1_second_q) begin
        if (sec_idx_q == mcma_pkg::KIDX_W'(mcma_pkg::KNOB_WINDOW - 1)) begin
          sec_idx_q  <= '0;
          sec_full_q <= 1'b1;
        end else begin
          sec_idx_q <= sec_idx_q + mcma_pkg::KIDX_W'(1);
        end
        cv_ring_q[cv_idx_q] <= s1_cv_q;
        if (cv_idx_q == mcma_pkg::CIDX_W'(mcma_pkg::CV_WINDOW - 1)) begin
          cv_idx_q <= '0;
        end else begin
          cv_idx_q <= cv_idx_q + mcma_pkg::CIDX_W'(1);
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign knob1_avg_o = out1_q;
  assign knob2_avg_o = out2_q;
  assign knob3_avg_o = out3_q;
  assign cv_avg_o    = out4_q;

  // The two update phases never land on the same transaction.
  a_one_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s1_valid_q && s1_pair_q && s1_second_q))
    else $error("pair and second update flagged together");

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= mcma_pkg::PHASE_W'(mcma_pkg::FRAME_TICKS))
    else $error("phase counter out of frame");

  a_pair_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv1 && s1_pair_q) |=> (pair_idx_q != $past(pair_idx_q)))
    else $error("pair ring index did not advance after a write");

  a_held3_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(adv1 && s1_second_q) |=> $stable(held3_q))
    else $error("knob three average changed outside its phase");

endmodule
